// ===== hw/rtl/ffha_pkg.sv =====
// Shared types and constants for the first-fit heap allocator.
// No dependencies; used by the controller, the datapath, the top level and the checker.
`default_nettype none

package ffha_pkg;

  localparam int unsigned HEAP_BYTES_DEF   = 256 * 1024;
  localparam int unsigned MAX_BLOCKS_DEF   = 64;
  localparam int unsigned HEADER_BYTES_DEF = 32;

  localparam int unsigned REQ_W    = 19;
  localparam int unsigned ADDR_W   = 18;
  localparam int unsigned STATUS_W = 3;
  localparam int unsigned MSR_W    = 8;
  localparam logic [MSR_W-1:0] MSR_RST = 8'd16;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK      = 3'd0,
    ST_ZERO    = 3'd1,
    ST_NOFIT   = 3'd2,
    ST_NULL    = 3'd3,
    ST_DOUBLE  = 3'd4,
    ST_UNKNOWN = 3'd5
  } status_e;

  typedef enum logic {
    CMD_ALLOC = 1'b0,
    CMD_FREE  = 1'b1
  } cmd_e;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_LOAD,
    OP_RD_PTR,
    OP_STEP,
    OP_HIT,
    OP_SPL_INIT,
    OP_SPL_RD,
    OP_SPL_WR,
    OP_TAIL,
    OP_MARK,
    OP_NXT_RD,
    OP_MERGE,
    OP_SHF_RD,
    OP_SHF_WR,
    OP_RESULT
  } op_e;

  typedef enum logic [3:0] {
    S_IDLE,
    S_CHK,
    S_RD,
    S_EV,
    S_ADEC,
    S_SRD,
    S_SWR,
    S_TAIL,
    S_MARK,
    S_DONE,
    S_NRD,
    S_NEV,
    S_SCHK,
    S_SHW
  } state_e;

  typedef struct packed {
    op_e     op;
    status_e st;
  } dp_cmd_t;

  typedef struct packed {
    logic is_free;     // current word is a free command
    logic req_zero;
    logic addr_zero;
    logic at_end;      // walk pointer reached the block count
    logic fit;
    logic match;
    logic rd_free;
    logic split_ok;
    logic at_tail;     // split shift has reached the slot after the hit
    logic has_next;
    logic shift_done;
  } dp_stat_t;

endpackage

`default_nettype wire

// ===== hw/rtl/first_fit_heap_allocator.sv =====
// First-fit heap allocator: one word in, one status word out on a one-cycle done_o strobe.
// Work grows with every block walked and every entry moved by a split or merge, set by one
// table access per cycle.
// One word at a time: start is taken again in the cycle the strobe shows.
// The receiver cannot stall; each done_o strobe lasts one cycle only, and status_o holds until the next result.
// Reset: asynchronous, active low; table holds one free block covering the heap.
`default_nettype none

module first_fit_heap_allocator #(
  parameter int unsigned HEAP_BYTES   = ffha_pkg::HEAP_BYTES_DEF,
  parameter int unsigned MAX_BLOCKS   = ffha_pkg::MAX_BLOCKS_DEF,
  parameter int unsigned HEADER_BYTES = ffha_pkg::HEADER_BYTES_DEF
) (
  input  wire                            clk_i,
  input  wire                            rst_ni,
  input  wire                            start,
  output logic                           busy,
  input  wire                            cmd_i,
  input  wire [ffha_pkg::REQ_W-1:0]      req_size_i,
  input  wire [ffha_pkg::ADDR_W-1:0]     free_addr_i,
  output logic                           done_o,
  output logic [ffha_pkg::STATUS_W-1:0]  status_o,
  input  wire                            cfg_we_i,
  input  wire [ffha_pkg::MSR_W-1:0]      cfg_wdata_i
);

  ffha_pkg::dp_cmd_t  dp_cmd;
  ffha_pkg::dp_stat_t dp_stat;

  ffha_ctrl u_ctrl (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start),
    .busy_o  (busy),
    .stat_i  (dp_stat),
    .cmd_o   (dp_cmd)
  );

  ffha_dp #(
    .HEAP_BYTES   (HEAP_BYTES),
    .MAX_BLOCKS   (MAX_BLOCKS),
    .HEADER_BYTES (HEADER_BYTES)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (dp_cmd),
    .stat_o      (dp_stat),
    .in_cmd_i    (cmd_i),
    .in_req_i    (req_size_i),
    .in_addr_i   (free_addr_i),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .done_o      (done_o),
    .status_o    (status_o)
  );

endmodule

`default_nettype wire

// ===== hw/rtl/ffha_dp.sv =====
// Datapath: block table memory, walk pointer, running offset and merge/split arithmetic.
// Depends on ffha_pkg; driven by ffha_ctrl through dp_cmd_t, reports through dp_stat_t.
`default_nettype none

module ffha_dp #(
  parameter int unsigned HEAP_BYTES   = ffha_pkg::HEAP_BYTES_DEF,
  parameter int unsigned MAX_BLOCKS   = ffha_pkg::MAX_BLOCKS_DEF,
  parameter int unsigned HEADER_BYTES = ffha_pkg::HEADER_BYTES_DEF
) (
  input  wire                               clk_i,
  input  wire                               rst_ni,
  input  wire ffha_pkg::dp_cmd_t            cmd_i,
  output ffha_pkg::dp_stat_t                stat_o,
  input  wire                               in_cmd_i,
  input  wire [ffha_pkg::REQ_W-1:0]         in_req_i,
  input  wire [ffha_pkg::ADDR_W-1:0]        in_addr_i,
  input  wire                               cfg_we_i,
  input  wire [ffha_pkg::MSR_W-1:0]         cfg_wdata_i,
  output logic                              done_o,
  output logic [ffha_pkg::STATUS_W-1:0]     status_o
);

  localparam int unsigned AW = $clog2(HEAP_BYTES);
  localparam int unsigned IW = (MAX_BLOCKS > 1) ? $clog2(MAX_BLOCKS) : 1;
  localparam int unsigned NW = $clog2(MAX_BLOCKS + 1);
  localparam int unsigned CW = ((AW > ffha_pkg::REQ_W) ? AW : ffha_pkg::REQ_W) + 2;
  localparam logic [CW-1:0] HDR_C     = CW'(HEADER_BYTES);
  localparam logic [AW-1:0] INIT_SIZE = AW'(HEAP_BYTES - HEADER_BYTES);
  localparam logic [NW-1:0] MAX_C     = NW'(MAX_BLOCKS);

  // one word per block: {free, data size}; header offsets follow from the running sum
  logic [AW:0] mem [MAX_BLOCKS];

  logic                        cmd_q;
  logic [ffha_pkg::REQ_W-1:0]  req_q;
  logic [ffha_pkg::ADDR_W-1:0] addr_q;
  logic [ffha_pkg::MSR_W-1:0]  msr_q;
  logic [NW-1:0]               cnt_q, ptr_q, hit_q;
  logic [CW-1:0]               off_q;
  logic                        prev_free_q, split_q, init0_q;
  logic [AW-1:0]               prev_size_q, hsize_q;
  logic                        rd_free_q;
  logic [AW-1:0]               rd_size_q;
  logic [1:0]                  r_q;
  logic                        done_q;
  logic [ffha_pkg::STATUS_W-1:0] status_q;

  logic            mem_we, rd_en;
  logic [IW-1:0]   mem_waddr, rd_addr;
  logic [AW:0]     mem_wdata;
  logic [NW-1:0]   ptr_dec, hit_inc, hit_dec, j_idx;
  logic [NW:0]     shf_src;
  logic            nf, pf;
  logic [CW-1:0]   s0, s_mrg;
  logic [1:0]      r_new;

  assign ptr_dec = ptr_q - NW'(1);
  assign hit_inc = hit_q + NW'(1);
  assign hit_dec = hit_q - NW'(1);
  assign shf_src = {1'b0, ptr_q} + (NW + 1)'(r_q);

  assign nf    = (hit_inc < cnt_q) && rd_free_q;
  assign pf    = (hit_q != '0) && prev_free_q;
  assign s0    = CW'(hsize_q) + (nf ? (CW'(rd_size_q) + HDR_C) : '0);
  assign s_mrg = pf ? (CW'(prev_size_q) + s0 + HDR_C) : s0;
  assign j_idx = pf ? hit_dec : hit_q;
  assign r_new = {1'b0, nf} + {1'b0, pf};

  always_comb begin
    stat_o.is_free    = cmd_q;
    stat_o.req_zero   = (req_q == '0);
    stat_o.addr_zero  = (addr_q == '0);
    stat_o.at_end     = (ptr_q >= cnt_q);
    stat_o.fit        = rd_free_q && (CW'(rd_size_q) >= CW'(req_q));
    stat_o.match      = ((off_q + HDR_C) == CW'(addr_q));
    stat_o.rd_free    = rd_free_q;
    stat_o.split_ok   = (CW'(hsize_q) > (CW'(req_q) + HDR_C + CW'(msr_q)))
                        && (cnt_q < MAX_C);
    stat_o.at_tail    = (ptr_q == hit_inc);
    stat_o.has_next   = (hit_inc < cnt_q);
    stat_o.shift_done = (r_q == 2'd0) || (shf_src >= {1'b0, cnt_q});
  end

  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = '0;
    mem_wdata = '0;
    rd_en     = 1'b0;
    rd_addr   = '0;
    case (cmd_i.op)
      ffha_pkg::OP_RD_PTR: begin
        rd_en   = 1'b1;
        rd_addr = ptr_q[IW-1:0];
      end
      ffha_pkg::OP_SPL_RD: begin
        rd_en   = 1'b1;
        rd_addr = ptr_dec[IW-1:0];
      end
      ffha_pkg::OP_SPL_WR, ffha_pkg::OP_SHF_WR: begin
        mem_we    = 1'b1;
        mem_waddr = ptr_q[IW-1:0];
        mem_wdata = {rd_free_q, rd_size_q};
      end
      ffha_pkg::OP_TAIL: begin
        mem_we    = 1'b1;
        mem_waddr = hit_inc[IW-1:0];
        mem_wdata = {1'b1, AW'(CW'(hsize_q) - CW'(req_q) - HDR_C)};
      end
      ffha_pkg::OP_MARK: begin
        mem_we    = 1'b1;
        mem_waddr = hit_q[IW-1:0];
        mem_wdata = {1'b0, split_q ? AW'(req_q) : hsize_q};
      end
      ffha_pkg::OP_NXT_RD: begin
        rd_en   = 1'b1;
        rd_addr = hit_inc[IW-1:0];
      end
      ffha_pkg::OP_MERGE: begin
        mem_we    = 1'b1;
        mem_waddr = j_idx[IW-1:0];
        mem_wdata = {1'b1, AW'(s_mrg)};
      end
      ffha_pkg::OP_SHF_RD: begin
        rd_en   = 1'b1;
        rd_addr = shf_src[IW-1:0];
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
  end

  // entry 0 reads as the whole heap until first written
  always_ff @(posedge clk_i) begin
    if (rd_en) begin
      if (init0_q && (rd_addr == '0)) begin
        rd_free_q <= 1'b1;
        rd_size_q <= INIT_SIZE;
      end else begin
        {rd_free_q, rd_size_q} <= mem[rd_addr];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    case (cmd_i.op)
      ffha_pkg::OP_LOAD: begin
        cmd_q       <= in_cmd_i;
        req_q       <= in_req_i;
        addr_q      <= in_addr_i;
        ptr_q       <= '0;
        off_q       <= '0;
        prev_free_q <= 1'b0;
        split_q     <= 1'b0;
        r_q         <= 2'd0;
      end
      ffha_pkg::OP_STEP: begin
        prev_free_q <= rd_free_q;
        prev_size_q <= rd_size_q;
        off_q       <= off_q + HDR_C + CW'(rd_size_q);
        ptr_q       <= ptr_q + NW'(1);
      end
      ffha_pkg::OP_HIT: begin
        hit_q   <= ptr_q;
        hsize_q <= rd_size_q;
      end
      ffha_pkg::OP_SPL_INIT: begin
        ptr_q   <= cnt_q;
        split_q <= 1'b1;
      end
      ffha_pkg::OP_SPL_WR: ptr_q <= ptr_dec;
      ffha_pkg::OP_MERGE: begin
        ptr_q <= j_idx + NW'(1);
        r_q   <= r_new;
      end
      ffha_pkg::OP_SHF_WR: ptr_q <= ptr_q + NW'(1);
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q    <= NW'(1);
      init0_q  <= 1'b1;
      msr_q    <= ffha_pkg::MSR_RST;
      done_q   <= 1'b0;
      status_q <= '0;
    end else begin
      if (cfg_we_i) begin
        msr_q <= cfg_wdata_i;
      end
      if (mem_we && (mem_waddr == '0)) begin
        init0_q <= 1'b0;
      end
      done_q <= (cmd_i.op == ffha_pkg::OP_RESULT);
      if (cmd_i.op == ffha_pkg::OP_RESULT) begin
        status_q <= cmd_i.st;
        cnt_q    <= cnt_q - NW'(r_q);
      end else if (cmd_i.op == ffha_pkg::OP_MARK) begin
        cnt_q <= cnt_q + NW'(split_q);
      end
    end
  end

  assign done_o   = done_q;
  assign status_o = status_q;

endmodule

`default_nettype wire

// ===== hw/rtl/ffha_ctrl.sv =====
// Controller FSM: sequences walk, split shift, merge and compaction of the block table.
// Depends on ffha_pkg; drives ffha_dp through dp_cmd_t.
`default_nettype none

module ffha_ctrl (
  input  wire                     clk_i,
  input  wire                     rst_ni,
  input  wire                     start_i,
  output logic                    busy_o,
  input  wire ffha_pkg::dp_stat_t stat_i,
  output ffha_pkg::dp_cmd_t       cmd_o
);

  ffha_pkg::state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ffha_pkg::S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      ffha_pkg::S_IDLE: if (start_i) state_d = ffha_pkg::S_CHK;
      ffha_pkg::S_CHK: begin
        if (stat_i.is_free ? stat_i.addr_zero : stat_i.req_zero) begin
          state_d = ffha_pkg::S_IDLE;
        end else begin
          state_d = ffha_pkg::S_RD;
        end
      end
      ffha_pkg::S_RD: state_d = stat_i.at_end ? ffha_pkg::S_IDLE : ffha_pkg::S_EV;
      ffha_pkg::S_EV: begin
        if (!stat_i.is_free) begin
          state_d = stat_i.fit ? ffha_pkg::S_ADEC : ffha_pkg::S_RD;
        end else if (stat_i.match) begin
          state_d = stat_i.rd_free ? ffha_pkg::S_IDLE : ffha_pkg::S_NRD;
        end else begin
          state_d = ffha_pkg::S_RD;
        end
      end
      ffha_pkg::S_ADEC: state_d = stat_i.split_ok ? ffha_pkg::S_SRD : ffha_pkg::S_MARK;
      ffha_pkg::S_SRD:  state_d = stat_i.at_tail ? ffha_pkg::S_TAIL : ffha_pkg::S_SWR;
      ffha_pkg::S_SWR:  state_d = ffha_pkg::S_SRD;
      ffha_pkg::S_TAIL: state_d = ffha_pkg::S_MARK;
      ffha_pkg::S_MARK: state_d = ffha_pkg::S_DONE;
      ffha_pkg::S_DONE: state_d = ffha_pkg::S_IDLE;
      ffha_pkg::S_NRD:  state_d = ffha_pkg::S_NEV;
      ffha_pkg::S_NEV:  state_d = ffha_pkg::S_SCHK;
      ffha_pkg::S_SCHK: state_d = stat_i.shift_done ? ffha_pkg::S_IDLE : ffha_pkg::S_SHW;
      ffha_pkg::S_SHW:  state_d = ffha_pkg::S_SCHK;
      default:          state_d = ffha_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    cmd_o.op = ffha_pkg::OP_NONE;
    cmd_o.st = ffha_pkg::ST_OK;
    case (state_q)
      ffha_pkg::S_IDLE: if (start_i) cmd_o.op = ffha_pkg::OP_LOAD;
      ffha_pkg::S_CHK: begin
        if (stat_i.is_free && stat_i.addr_zero) begin
          cmd_o.op = ffha_pkg::OP_RESULT;
          cmd_o.st = ffha_pkg::ST_NULL;
        end else if (!stat_i.is_free && stat_i.req_zero) begin
          cmd_o.op = ffha_pkg::OP_RESULT;
          cmd_o.st = ffha_pkg::ST_ZERO;
        end
      end
      ffha_pkg::S_RD: begin
        if (stat_i.at_end) begin
          cmd_o.op = ffha_pkg::OP_RESULT;
          cmd_o.st = stat_i.is_free ? ffha_pkg::ST_UNKNOWN : ffha_pkg::ST_NOFIT;
        end else begin
          cmd_o.op = ffha_pkg::OP_RD_PTR;
        end
      end
      ffha_pkg::S_EV: begin
        if (!stat_i.is_free) begin
          cmd_o.op = stat_i.fit ? ffha_pkg::OP_HIT : ffha_pkg::OP_STEP;
        end else if (stat_i.match) begin
          if (stat_i.rd_free) begin
            cmd_o.op = ffha_pkg::OP_RESULT;
            cmd_o.st = ffha_pkg::ST_DOUBLE;
          end else begin
            cmd_o.op = ffha_pkg::OP_HIT;
          end
        end else begin
          cmd_o.op = ffha_pkg::OP_STEP;
        end
      end
      ffha_pkg::S_ADEC: if (stat_i.split_ok) cmd_o.op = ffha_pkg::OP_SPL_INIT;
      ffha_pkg::S_SRD:  if (!stat_i.at_tail) cmd_o.op = ffha_pkg::OP_SPL_RD;
      ffha_pkg::S_SWR:  cmd_o.op = ffha_pkg::OP_SPL_WR;
      ffha_pkg::S_TAIL: cmd_o.op = ffha_pkg::OP_TAIL;
      ffha_pkg::S_MARK: cmd_o.op = ffha_pkg::OP_MARK;
      ffha_pkg::S_DONE: cmd_o.op = ffha_pkg::OP_RESULT;
      ffha_pkg::S_NRD:  if (stat_i.has_next) cmd_o.op = ffha_pkg::OP_NXT_RD;
      ffha_pkg::S_NEV:  cmd_o.op = ffha_pkg::OP_MERGE;
      ffha_pkg::S_SCHK: cmd_o.op = stat_i.shift_done ? ffha_pkg::OP_RESULT : ffha_pkg::OP_SHF_RD;
      ffha_pkg::S_SHW:  cmd_o.op = ffha_pkg::OP_SHF_WR;
      default: ;
    endcase
  end

  assign busy_o = (state_q != ffha_pkg::S_IDLE);

endmodule

`default_nettype wire

// ===== hw/rtl/ffha_chk.sv =====
// Port-level checker for the first-fit heap allocator, bound to the top level.
// Depends on ffha_pkg for the status codes.
`default_nettype none

module ffha_chk (
  input wire                           clk_i,
  input wire                           rst_ni,
  input wire                           start,
  input wire                           busy,
  input wire                           done_o,
  input wire [ffha_pkg::STATUS_W-1:0]  status_o
);

  // a taken word makes the block busy
  assert property (@(posedge clk_i) disable iff (!rst_ni) start && !busy |=> busy)
    else $error("accepted word did not raise busy");

  // result strobes only once the block has gone idle
  assert property (@(posedge clk_i) disable iff (!rst_ni) done_o |-> !busy)
    else $error("result strobe while busy");

  assert property (@(posedge clk_i) disable iff (!rst_ni) done_o |=> !done_o)
    else $error("result strobe longer than one cycle");

  // every result follows a busy period
  assert property (@(posedge clk_i) disable iff (!rst_ni) done_o |-> $past(busy))
    else $error("result without a word in work");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> (status_o <= ffha_pkg::ST_UNKNOWN))
    else $error("status code out of range");

endmodule

bind first_fit_heap_allocator ffha_chk u_ffha_chk (
  .clk_i    (clk_i),
  .rst_ni   (rst_ni),
  .start    (start),
  .busy     (busy),
  .done_o   (done_o),
  .status_o (status_o)
);

`default_nettype wire
